FILE: sv/mme_pkg.sv
// mme_pkg: shared types, constants and helpers of the matrix multiply engine
// used by mme_mac and matrix_multiply_engine; depends on nothing
`default_nettype none

package mme_pkg;

  // store geometry
  localparam int MAX_DIM = 16;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  // field widths
  localparam int IDX_W   = 4;
  localparam int ELEM_W  = 16;
  localparam int PROD_W  = 2 * ELEM_W;
  localparam int ACC_W   = 40;
  localparam int CMD_W   = 2;
  localparam int CFG_W   = 5;
  localparam int REG_W   = 2;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_WR_A    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // register indexes
  localparam logic [REG_W-1:0] REG_ROWS_M  = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_N = 2'd1;
  localparam logic [REG_W-1:0] REG_COLS_L  = 2'd2;

  // control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

  // status back from the multiply-accumulate unit
  typedef struct packed {
    logic busy;
  } mac_stat_t;

  // register value clipped to the store size
  function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] r);
    if (32'(r) > MAX_DIM) begin
      return CNT_W'(MAX_DIM);
    end
    return CNT_W'(r);
  endfunction

endpackage

`default_nettype wire

FILE: sv/mme_ram.sv
// mme_ram: generic single-write, single-read RAM with a registered read
// standalone, depends on nothing
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: sv/mme_mac.sv
// mme_mac: pipelined multiply-accumulate over element pairs read from the stores
// depends on mme_pkg
`default_nettype none

module mme_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire mme_pkg::mac_ctrl_t                  ctrl,
  input  wire logic signed [mme_pkg::ELEM_W-1:0]   a_data,
  input  wire logic signed [mme_pkg::ELEM_W-1:0]   b_data,
  output logic signed      [mme_pkg::ACC_W-1:0]    acc,
  output mme_pkg::mac_stat_t                       stat
);

  logic                                 data_valid;
  logic                                 prod_valid;
  logic signed [mme_pkg::PROD_W-1:0]    prod;

  // valid tracking for ram data and the product register
  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      data_valid <= ctrl.issue;
      prod_valid <= data_valid;
    end
  end

  // multiply stage, then accumulate stage
  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (ctrl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + {{(mme_pkg::ACC_W - mme_pkg::PROD_W){prod[mme_pkg::PROD_W-1]}}, prod};
    end
  end

  assign stat.busy = data_valid | prod_valid;

endmodule

`default_nettype wire

FILE: sv/matrix_multiply_engine.sv
// matrix_multiply_engine: top level, element stores, sequencer and result register
// depends on mme_pkg, mme_ram, mme_mac
//
//   channel  dir  signals                           content
//   s_*      in   s_tvalid s_tready s_tdata s_tuser  load or compute item
//   m_*      out  m_tvalid m_tready m_tdata m_tuser  C element item
//   cfg_*    in   cfg_we cfg_index cfg_data          rows_m, inner_n, cols_l
//
// a load item is taken in idle; a compute item runs the sequencer through run and
// drain, with one shared multiply-accumulate walking the inner dimension, the
// clipped inner_n, one element pair a cycle through the two store read ports.
// a compute out of range or with n zero skips run and goes straight to drain.
// reset is synchronous; the stores are not cleared.
// a finished result waits in the output register while the next item is taken.
`default_nettype none

module matrix_multiply_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,   // row_index, col_index, elem_value
  input  wire logic [mme_pkg::CMD_W-1:0]   s_tuser,   // cmd
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [mme_pkg::ACC_W-1:0]        m_tdata,   // product_value
  output logic                             m_tuser,   // range_error
  input  wire logic                        cfg_we,
  input  wire logic [mme_pkg::REG_W-1:0]   cfg_index,
  input  wire logic [mme_pkg::CFG_W-1:0]   cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_t;

  state_t                          state;
  logic [mme_pkg::CFG_W-1:0]       rows_m;
  logic [mme_pkg::CFG_W-1:0]       inner_n;
  logic [mme_pkg::CFG_W-1:0]       cols_l;
  logic [mme_pkg::IDX_W-1:0]       row_q;
  logic [mme_pkg::IDX_W-1:0]       col_q;
  logic                            err_q;
  logic [mme_pkg::CNT_W-1:0]       n_q;
  logic [mme_pkg::CNT_W-1:0]       k;

  logic [mme_pkg::IDX_W-1:0]       in_row;
  logic [mme_pkg::IDX_W-1:0]       in_col;
  logic [mme_pkg::ELEM_W-1:0]      in_elem;
  logic                            in_acc;
  logic                            in_compute;
  logic                            in_err;
  logic [mme_pkg::CNT_W-1:0]       in_n;
  logic                            in_store;
  logic                            wr_a_en;
  logic                            wr_b_en;
  logic [mme_pkg::ADDR_W-1:0]      wr_addr;
  logic [mme_pkg::ADDR_W-1:0]      rd_a_addr;
  logic [mme_pkg::ADDR_W-1:0]      rd_b_addr;
  logic [mme_pkg::ELEM_W-1:0]      a_rd;
  logic [mme_pkg::ELEM_W-1:0]      b_rd;
  logic signed [mme_pkg::ACC_W-1:0] acc;
  mme_pkg::mac_ctrl_t              mac_ctrl;
  mme_pkg::mac_stat_t              mac_stat;
  logic                            out_free;
  logic                            out_load;

  // input item unpacking and decode
  assign in_row     = s_tdata[3:0];
  assign in_col     = s_tdata[7:4];
  assign in_elem    = s_tdata[23:8];
  assign s_tready   = (state == S_IDLE);
  assign in_acc     = s_tvalid & s_tready;
  assign in_compute = in_acc & (s_tuser == mme_pkg::CMD_COMPUTE);
  assign in_err     = (32'(in_row) >= 32'(mme_pkg::eff_size(rows_m))) ||
                      (32'(in_col) >= 32'(mme_pkg::eff_size(cols_l)));
  assign in_n       = mme_pkg::eff_size(inner_n);

  // store writes, only taken while no compute reads the stores
  assign in_store = (32'(in_row) < mme_pkg::MAX_DIM) && (32'(in_col) < mme_pkg::MAX_DIM);
  assign wr_a_en  = in_acc & in_store & (s_tuser == mme_pkg::CMD_WR_A);
  assign wr_b_en  = in_acc & in_store & (s_tuser == mme_pkg::CMD_WR_B);
  assign wr_addr  = mme_pkg::ADDR_W'(32'(in_row) * mme_pkg::MAX_DIM + 32'(in_col));

  // read addresses: row of A and column of B at step k
  assign rd_a_addr = mme_pkg::ADDR_W'(32'(row_q) * mme_pkg::MAX_DIM +
                                      32'(k[mme_pkg::DIM_W-1:0]));
  assign rd_b_addr = mme_pkg::ADDR_W'(32'(k[mme_pkg::DIM_W-1:0]) * mme_pkg::MAX_DIM +
                                      32'(col_q));

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (mme_pkg::CELLS)
  ) u_ram_a (
    .clk   (clk),
    .we    (wr_a_en),
    .waddr (wr_addr),
    .wdata (in_elem),
    .raddr (rd_a_addr),
    .rdata (a_rd)
  );

  mme_ram #(
    .WIDTH (mme_pkg::ELEM_W),
    .DEPTH (mme_pkg::CELLS)
  ) u_ram_b (
    .clk   (clk),
    .we    (wr_b_en),
    .waddr (wr_addr),
    .wdata (in_elem),
    .raddr (rd_b_addr),
    .rdata (b_rd)
  );

  // multiply-accumulate control
  assign mac_ctrl.clear = in_compute;
  assign mac_ctrl.issue = (state == S_RUN);

  mme_mac u_mac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (mac_ctrl),
    .a_data (a_rd),
    .b_data (b_rd),
    .acc    (acc),
    .stat   (mac_stat)
  );

  // result register is free or emptied this cycle; load when the sum is final
  assign out_free = ~m_tvalid | m_tready;
  assign out_load = (state == S_DRAIN) && !mac_stat.busy && out_free;

  // sequencer, configuration registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      rows_m   <= mme_pkg::CFG_RESET;
      inner_n  <= mme_pkg::CFG_RESET;
      cols_l   <= mme_pkg::CFG_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mme_pkg::REG_ROWS_M:  rows_m  <= cfg_data;
          mme_pkg::REG_INNER_N: inner_n <= cfg_data;
          mme_pkg::REG_COLS_L:  cols_l  <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_compute) begin
            row_q <= in_row;
            col_q <= in_col;
            err_q <= in_err;
            n_q   <= in_n;
            k     <= '0;
            state <= (!in_err && in_n != '0) ? S_RUN : S_DRAIN;
          end
        end
        S_RUN: begin
          k <= k + mme_pkg::CNT_W'(1);
          if (k == n_q - mme_pkg::CNT_W'(1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            m_tdata  <= err_q ? '0 : acc;
            m_tuser  <= err_q;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stores are never written while a compute walks them
  a_no_write_in_compute: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (!wr_a_en && !wr_b_en))
    else $error("store write during compute");

  // a range error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("range error with nonzero value");

  // the inner step stays below the clipped inner size
  a_k_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> (k < n_q))
    else $error("inner step out of range");

  // a compute item closes the input until its result is placed
  a_compute_blocks: assert property (@(posedge clk) disable iff (rst)
    in_compute |=> !s_tready)
    else $error("input open right after compute");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for matrix_multiply_engine, loads A and B over the
// input stream, predicts each C element locally or takes a known one, and checks each result item
// depends on mme_pkg and the engine RTL
module testbench;
  import mme_pkg::*;

  // codes the package leaves unnamed
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;

  localparam int LIMIT       = 1_000_000;
  localparam int SETTLE      = 30;
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 150;
  localparam int LONG_HOLD   = 400;
  localparam int MAX_PRINT   = 20;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    err;
  } c_elem_t;

  typedef struct packed {
    logic              is_reg;
    logic [1:0]        code;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [ELEM_W-1:0] value;
    logic              typed;
    c_elem_t           known_c;
  } step_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;    // row_index, col_index, elem_value
  logic [CMD_W-1:0]  s_tuser;    // cmd
  logic              m_tvalid;
  logic              m_tready;
  logic [ACC_W-1:0]  m_tdata;    // product_value
  logic              m_tuser;    // range_error
  logic              cfg_we;
  logic [REG_W-1:0]  cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  // local copy of the stores and sizes
  logic signed [ELEM_W-1:0] a_elems [CELLS];
  logic signed [ELEM_W-1:0] b_elems [CELLS];
  bit                       a_loaded [CELLS];
  bit                       b_loaded [CELLS];
  logic [CFG_W-1:0]         rows_cfg, inner_cfg, cols_cfg;

  c_elem_t pending_c [$];

  int send_gap = 0;
  int recv_gap = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int range_errs_seen = 0;
  int mismatch_count = 0;

  matrix_multiply_engine dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, pending_c.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // output side backpressure, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap);
    end
  end

  task automatic report_mismatch(string what, logic [ACC_W-1:0] got, logic [ACC_W-1:0] want);
    if (mismatch_count < MAX_PRINT)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // compare each result item with the oldest pending C element
  always @(posedge clk) begin : check_results
    c_elem_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser === 1'b1) range_errs_seen++;
      if (pending_c.size() == 0) begin
        report_mismatch("result item with nothing pending", m_tdata, '0);
      end else begin
        want = pending_c.pop_front();
        if (m_tdata !== want.value) report_mismatch("product_value", m_tdata, want.value);
        if (m_tuser !== want.err) report_mismatch("range_error", ACC_W'(m_tuser), ACC_W'(want.err));
      end
    end
  end

  // register value clipped to the store size
  function automatic int clip_dim(logic [CFG_W-1:0] r);
    return (int'(r) > MAX_DIM) ? MAX_DIM : int'(r);
  endfunction

  function automatic bit out_of_range(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    return int'(row) >= clip_dim(rows_cfg) || int'(col) >= clip_dim(cols_cfg);
  endfunction

  // expected C element: exact sum of A[row][k] * B[k][col]
  function automatic c_elem_t calc_c_element(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    c_elem_t res;
    logic signed [ACC_W-1:0] acc;
    res = '0;
    acc = '0;
    if (out_of_range(row, col)) begin
      res.err = 1'b1;
      return res;
    end
    for (int k = 0; k < clip_dim(inner_cfg); k++)
      acc = acc + a_elems[row * MAX_DIM + k] * b_elems[k * MAX_DIM + col];
    res.value = acc;
    return res;
  endfunction

  // every operand the compute would read has been loaded
  function automatic bit operands_loaded(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col);
    if (out_of_range(row, col)) return 1'b1;
    for (int k = 0; k < clip_dim(inner_cfg); k++)
      if (!a_loaded[row * MAX_DIM + k] || !b_loaded[k * MAX_DIM + col]) return 1'b0;
    return 1'b1;
  endfunction

  // update the local stores or queue the C element once an item is taken
  task automatic apply_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                            logic [ELEM_W-1:0] val, logic typed, c_elem_t known_c);
    case (cmd)
      CMD_WR_A: begin
        a_elems[row * MAX_DIM + col] = val;
        a_loaded[row * MAX_DIM + col] = 1'b1;
      end
      CMD_WR_B: begin
        b_elems[row * MAX_DIM + col] = val;
        b_loaded[row * MAX_DIM + col] = 1'b1;
      end
      CMD_COMPUTE: begin
        pending_c.push_back(typed ? known_c : calc_c_element(row, col));
      end
      default: ;
    endcase
  endtask

  task automatic send_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic [ELEM_W-1:0] val, logic typed, c_elem_t known_c);
    @(negedge clk);
    if ($urandom_range(99) < send_gap) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, col, row};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    apply_item(cmd, row, col, val, typed, known_c);
    items_sent++;
  endtask

  task automatic lower_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_c.size() != 0) @(posedge clk);
  endtask

  // registers change only with the engine idle
  task automatic write_register(logic [REG_W-1:0] idx, logic [CFG_W-1:0] val);
    lower_valid();
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ROWS_M:  rows_cfg = val;
      REG_INNER_N: inner_cfg = val;
      REG_COLS_L:  cols_cfg = val;
      default: ;
    endcase
  endtask

  // random item; a compute that would read an unloaded entry loads it instead
  task automatic send_random_item();
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row, col;
    logic [ELEM_W-1:0] val;
    int pick;
    bit filled;
    pick = $urandom_range(99);
    row = IDX_W'($urandom_range(15));
    col = IDX_W'($urandom_range(15));
    val = ELEM_W'($urandom);
    if (pick < 30) cmd = CMD_WR_A;
    else if (pick < 60) cmd = CMD_WR_B;
    else if (pick < 95) cmd = CMD_COMPUTE;
    else cmd = CMD_UNUSED;
    if (cmd == CMD_COMPUTE && !operands_loaded(row, col)) begin
      filled = 1'b0;
      for (int k = 0; k < clip_dim(inner_cfg) && !filled; k++) begin
        if (!a_loaded[row * MAX_DIM + k]) begin
          cmd = CMD_WR_A;
          col = IDX_W'(k);
          filled = 1'b1;
        end else if (!b_loaded[k * MAX_DIM + col]) begin
          cmd = CMD_WR_B;
          row = IDX_W'(k);
          filled = 1'b1;
        end
      end
    end
    send_item(cmd, row, col, val, 1'b0, '0);
  endtask

  // size register value, biased toward the extremes
  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return 5'd1;
      1: return 5'd16;
      2: return 5'd31;
      3: return CFG_W'($urandom_range(17, 31));
      4: return CFG_W'($urandom_range(0, 2));
      default: return CFG_W'($urandom_range(1, 16));
    endcase
  endfunction

  function automatic step_t reg_step(logic [REG_W-1:0] idx, logic [CFG_W-1:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.code = idx;
    s.value = ELEM_W'(val);
    return s;
  endfunction

  function automatic step_t item_step(logic [CMD_W-1:0] cmd, int row, int col,
                                     logic [ELEM_W-1:0] val);
    step_t s;
    s = '0;
    s.code = cmd;
    s.row = IDX_W'(row);
    s.col = IDX_W'(col);
    s.value = val;
    return s;
  endfunction

  function automatic step_t known_step(int row, int col, logic signed [ACC_W-1:0] value,
                                       logic err);
    step_t s;
    s = item_step(CMD_COMPUTE, row, col, '0);
    s.typed = 1'b1;
    s.known_c.value = value;
    s.known_c.err = err;
    return s;
  endfunction

  // main sequence
  initial begin : stimulus
    step_t steps [$];
    int mode;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    rows_cfg = CFG_RESET;
    inner_cfg = CFG_RESET;
    cols_cfg = CFG_RESET;
    for (int i = 0; i < CELLS; i++) begin
      a_elems[i] = '0;
      b_elems[i] = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed: extreme products, unused command and index, zero and saturated sizes
    steps.push_back(reg_step(REG_INNER_N, 5'd1));
    steps.push_back(item_step(CMD_WR_A, 0, 0, 16'h8000));
    steps.push_back(item_step(CMD_WR_B, 0, 0, 16'h8000));
    steps.push_back(known_step(0, 0, 40'sd1073741824, 1'b0));
    steps.push_back(item_step(CMD_WR_A, 15, 0, 16'h7fff));
    steps.push_back(item_step(CMD_WR_B, 0, 15, 16'h8000));
    steps.push_back(known_step(15, 15, -40'sd1073709056, 1'b0));
    steps.push_back(item_step(CMD_WR_B, 0, 15, 16'h7fff));
    steps.push_back(known_step(15, 15, 40'sd1073676289, 1'b0));
    steps.push_back(item_step(CMD_UNUSED, 15, 15, 16'hffff));
    steps.push_back(item_step(CMD_COMPUTE, 0, 15, '0));
    steps.push_back(reg_step(REG_UNUSED, 5'd31));
    steps.push_back(item_step(CMD_COMPUTE, 15, 0, '0));
    steps.push_back(reg_step(REG_ROWS_M, 5'd0));
    steps.push_back(known_step(0, 0, '0, 1'b1));
    steps.push_back(reg_step(REG_ROWS_M, 5'd31));
    steps.push_back(reg_step(REG_COLS_L, 5'd1));
    steps.push_back(known_step(15, 1, '0, 1'b1));
    steps.push_back(item_step(CMD_COMPUTE, 15, 0, '0));
    steps.push_back(reg_step(REG_INNER_N, 5'd0));
    steps.push_back(known_step(7, 0, '0, 1'b0));
    steps.push_back(item_step(CMD_WR_A, 15, 15, 16'hffff));
    steps.push_back(reg_step(REG_COLS_L, 5'd0));
    steps.push_back(known_step(0, 0, '0, 1'b1));
    foreach (steps[i]) begin
      if (steps[i].is_reg)
        write_register(steps[i].code, steps[i].value[CFG_W-1:0]);
      else
        send_item(steps[i].code, steps[i].row, steps[i].col, steps[i].value,
                  steps[i].typed, steps[i].known_c);
    end

    // random phases: receiver-heavy idling, sender-heavy idling, then none
    for (int p = 0; p < PHASES; p++) begin
      mode = p / 4;
      send_gap = (mode == 0) ? 12 : (mode == 1) ? 79 : 0;
      recv_gap = (mode == 0) ? 79 : (mode == 1) ? 12 : 0;
      if (p == 0) begin
        write_register(REG_ROWS_M, 5'd16);
        write_register(REG_INNER_N, 5'd16);
        write_register(REG_COLS_L, 5'd16);
      end else if (p == 1) begin
        write_register(REG_ROWS_M, 5'd31);
        write_register(REG_INNER_N, 5'd31);
        write_register(REG_COLS_L, 5'd31);
      end else begin
        write_register(REG_ROWS_M, pick_size());
        write_register(REG_INNER_N, pick_size());
        write_register(REG_COLS_L, pick_size());
      end
      // long output stall while items keep coming
      if (p == 9) hold_asked++;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // sender waits for every pending result mid phase
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          lower_valid();
          wait_drained();
        end
        send_random_item();
      end
    end

    lower_valid();
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    $display("covered %0d items and %0d C elements, %0d of them out of range,",
             items_sent, results_seen, range_errs_seen);
    $display("three idle patterns, a long output stall and zero to saturated sizes");
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
